>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on the rising edge, off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked on the rising edge, also during reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> design/lfpd_pkg.sv
package lfpd_pkg;

  localparam int SPEED_MAX = 1023;
  localparam int ERR_LIMIT = 2046;

  // x / 100 == (x * 5243) >> 19 for every 10-bit x
  localparam logic [12:0] DIV100_MULT = 13'd5243;
  localparam int DIV100_SHIFT = 19;

  localparam logic [1:0] CFG_GAIN_P = 2'd0;
  localparam logic [1:0] CFG_GAIN_D = 2'd1;
  localparam logic [1:0] CFG_POWER  = 2'd2;

  localparam logic [7:0] GAIN_P_RESET = 8'd30;
  localparam logic [7:0] GAIN_D_RESET = 8'd1;
  localparam logic [6:0] POWER_RESET  = 7'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_PMUL,
    ST_DMUL,
    ST_SUM,
    ST_DIV,
    ST_SCALE
  } state_t;

  typedef struct packed {
    logic capture;
    logic calc_err;
    logic calc_p;
    logic calc_d;
    logic calc_sum;
    logic calc_div;
    logic load_out;
  } ctrl_t;

endpackage

>>> design/line_follow_pd_motor_drive_top.sv
// a new item is taken only in idle, once the last one is loaded, then runs the
// controller's step sequence (error, two dependent gain multiplies, motor split,
// divide, pwm scale), holding in the scale step until the output register is free
// a finished result waits in the output register while the next item is taken
// reset: synchronous, gains 30 and 1, power 100, error and history zero, forward
module line_follow_pd_motor_drive_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         left_sensors,
  input  logic [7:0]         right_sensors,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         left_pwm,
  output logic [9:0]         right_pwm,
  output logic               left_reverse,
  output logic               right_reverse,
  output logic               left_dir_toggle,
  output logic               right_dir_toggle,
  output logic               line_seen,
  output logic signed [11:0] position_error
);
  import lfpd_pkg::*;
  `include "assert_macros.svh"

  ctrl_t cmd;

  lfpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lfpd_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .left_sensors     (left_sensors),
    .right_sensors    (right_sensors),
    .left_pwm         (left_pwm),
    .right_pwm        (right_pwm),
    .left_reverse     (left_reverse),
    .right_reverse    (right_reverse),
    .left_dir_toggle  (left_dir_toggle),
    .right_dir_toggle (right_dir_toggle),
    .line_seen        (line_seen),
    .position_error   (position_error)
  );

  `ASSERT_CLK(a_one_item, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `ASSERT_CLK(a_no_overwrite, clk, rst, cmd.load_out |-> (!out_valid || out_ready))
  `ASSERT_CLK(a_err_range, clk, rst, out_valid |-> (position_error <= 12'sd2046 && position_error >= -12'sd2046))
  `ASSERT_CLK(a_one_reverse, clk, rst, out_valid |-> !(left_reverse && right_reverse))

endmodule

>>> design/lfpd_ctrl.sv
module lfpd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lfpd_pkg::ctrl_t cmd
);
  import lfpd_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ERR;
      ST_ERR:   state_next = ST_PMUL;
      ST_PMUL:  state_next = ST_DMUL;
      ST_DMUL:  state_next = ST_SUM;
      ST_SUM:   state_next = ST_DIV;
      ST_DIV:   state_next = ST_SCALE;
      ST_SCALE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_ERR:   cmd.calc_err = 1'b1;
      ST_PMUL:  cmd.calc_p   = 1'b1;
      ST_DMUL:  cmd.calc_d   = 1'b1;
      ST_SUM:   cmd.calc_sum = 1'b1;
      ST_DIV:   cmd.calc_div = 1'b1;
      ST_SCALE: cmd.load_out = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

>>> design/lfpd_datapath.sv
module lfpd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  lfpd_pkg::ctrl_t    cmd,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic [7:0]         left_sensors,
  input  logic [7:0]         right_sensors,
  output logic [9:0]         left_pwm,
  output logic [9:0]         right_pwm,
  output logic               left_reverse,
  output logic               right_reverse,
  output logic               left_dir_toggle,
  output logic               right_dir_toggle,
  output logic               line_seen,
  output logic signed [11:0] position_error
);
  import lfpd_pkg::*;

  logic [7:0] gain_p;
  logic [7:0] gain_d;
  logic [6:0] power_percent;

  logic [7:0] lsens;
  logic [7:0] rsens;
  logic       seen;

  logic signed [11:0] error_reg;
  logic signed [19:0] p_term;
  logic signed [19:0] prev_p_term;
  logic signed [29:0] d_term;
  logic               left_dir_reg;
  logic               right_dir_reg;
  logic               tog_l;
  logic               tog_r;
  logic [9:0]         mag_l;
  logic [9:0]         mag_r;
  logic [3:0]         quo_l;
  logic [3:0]         quo_r;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= GAIN_P_RESET;
      gain_d        <= GAIN_D_RESET;
      power_percent <= POWER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GAIN_P: gain_p        <= cfg_data;
        CFG_GAIN_D: gain_d        <= cfg_data;
        CFG_POWER:  power_percent <= cfg_data[6:0];
        default:    ;
      endcase
    end
  end

  // position error
  logic [6:0]         wt_l;
  logic [6:0]         wt_r;
  logic signed [7:0]  wt_sum;
  logic signed [12:0] err_dbl;
  logic signed [11:0] err_new;

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      wt_l[i] = lsens[6 - i];
      wt_r[i] = rsens[6 - i];
    end
    wt_sum  = $signed({1'b0, wt_r}) - $signed({1'b0, wt_l});
    err_dbl = $signed({error_reg, 1'b0});
    if (seen) begin
      err_new = {{4{wt_sum[7]}}, wt_sum};
    end else if (err_dbl > 13'sd2046) begin
      err_new = 12'(ERR_LIMIT);
    end else if (err_dbl < -13'sd2046) begin
      err_new = -12'sd2046;
    end else begin
      err_new = err_dbl[11:0];
    end
  end

  // gain products
  logic signed [20:0] p_full;
  logic signed [20:0] p_diff;
  logic signed [29:0] d_full;

  assign p_full = $signed({1'b0, gain_p}) * error_reg;
  assign p_diff = $signed({p_term[19], p_term}) - $signed({prev_p_term[19], prev_p_term});
  assign d_full = $signed({1'b0, gain_d}) * p_diff;

  // motor split
  logic signed [30:0] o_sum;
  logic signed [10:0] o_clamp;
  logic signed [10:0] o_neg;
  logic [9:0]         o_mag;
  logic signed [11:0] other;
  logic signed [11:0] spd_l;
  logic signed [11:0] spd_r;
  logic signed [11:0] neg_l;
  logic signed [11:0] neg_r;

  always_comb begin
    o_sum = $signed({d_term[29], d_term}) + $signed({{11{p_term[19]}}, p_term});
    if (o_sum > 31'sd1023) begin
      o_clamp = 11'(SPEED_MAX);
    end else if (o_sum < -31'sd1023) begin
      o_clamp = -11'sd1023;
    end else begin
      o_clamp = o_sum[10:0];
    end
    o_neg = -o_clamp;
    o_mag = o_clamp[10] ? o_neg[9:0] : o_clamp[9:0];
    other = 12'(SPEED_MAX) - $signed({1'b0, o_mag, 1'b0});
    spd_l = 12'(SPEED_MAX);
    spd_r = 12'(SPEED_MAX);
    if (o_clamp > 11'sd0) begin
      spd_r = other;
    end else if (o_clamp < 11'sd0) begin
      spd_l = other;
    end
    neg_l = -spd_l;
    neg_r = -spd_r;
  end

  // divide by 100 and scale
  logic [22:0] prod_l;
  logic [22:0] prod_r;
  logic [10:0] scl_l;
  logic [10:0] scl_r;

  assign prod_l = mag_l * DIV100_MULT;
  assign prod_r = mag_r * DIV100_MULT;
  assign scl_l  = quo_l * power_percent;
  assign scl_r  = quo_r * power_percent;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_reg     <= '0;
      prev_p_term   <= '0;
      left_dir_reg  <= 1'b0;
      right_dir_reg <= 1'b0;
    end else begin
      if (cmd.calc_err) error_reg <= err_new;
      if (cmd.calc_d) prev_p_term <= p_term;
      if (cmd.calc_sum) begin
        left_dir_reg  <= spd_l[11];
        right_dir_reg <= spd_r[11];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lsens <= left_sensors;
      rsens <= right_sensors;
      seen  <= (left_sensors | right_sensors) != 8'd0;
    end
    if (cmd.calc_p) p_term <= p_full[19:0];
    if (cmd.calc_d) d_term <= d_full;
    if (cmd.calc_sum) begin
      tog_l <= spd_l[11] != left_dir_reg;
      tog_r <= spd_r[11] != right_dir_reg;
      mag_l <= spd_l[11] ? neg_l[9:0] : spd_l[9:0];
      mag_r <= spd_r[11] ? neg_r[9:0] : spd_r[9:0];
    end
    if (cmd.calc_div) begin
      quo_l <= prod_l[DIV100_SHIFT +: 4];
      quo_r <= prod_r[DIV100_SHIFT +: 4];
    end
    if (cmd.load_out) begin
      left_pwm         <= (scl_l > 11'(SPEED_MAX)) ? 10'(SPEED_MAX) : scl_l[9:0];
      right_pwm        <= (scl_r > 11'(SPEED_MAX)) ? 10'(SPEED_MAX) : scl_r[9:0];
      left_reverse     <= left_dir_reg;
      right_reverse    <= right_dir_reg;
      left_dir_toggle  <= tog_l;
      right_dir_toggle <= tog_r;
      line_seen        <= seen;
      position_error   <= error_reg;
    end
  end

endmodule

>>> bench/line_follow_pd_motor_drive_top_tb.sv
`timescale 1ns / 100ps

module line_follow_pd_motor_drive_top_tb;
  import lfpd_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 250;

  typedef struct {
    logic [9:0]         lpwm;
    logic [9:0]         rpwm;
    logic               lrev;
    logic               rrev;
    logic               ltog;
    logic               rtog;
    logic               seen;
    logic signed [11:0] err;
  } drive_result_t;

  class motor_drive_tracker;
    bit [7:0]           gain_p;
    bit [7:0]           gain_d;
    bit [6:0]           power;
    logic signed [11:0] err_q;
    logic signed [19:0] prev_p;
    bit                 ldir;
    bit                 rdir;
    drive_result_t      pending_drives[$];
    int                 mismatches;

    function new();
      gain_p = GAIN_P_RESET;
      gain_d = GAIN_D_RESET;
      power = POWER_RESET;
      err_q = '0;
      prev_p = '0;
      ldir = 1'b0;
      rdir = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        CFG_GAIN_P: gain_p = data;
        CFG_GAIN_D: gain_d = data;
        CFG_POWER:  power = data[6:0];
        default: ;
      endcase
    endfunction

    function longint scale_pwm(longint mag);
      longint v;
      v = (mag / 100) * longint'(power);
      return (v > SPEED_MAX) ? SPEED_MAX : v;
    endfunction

    function void note_scan(logic [7:0] lft, logic [7:0] rgt);
      int e;
      longint p, d, o, ls, rs;
      bit nl, nr;
      drive_result_t want;
      want.seen = (lft | rgt) != 8'd0;
      if (want.seen) begin
        e = 0;
        for (int i = 0; i < 7; i++) begin
          if (lft[i]) e -= (64 >> i);
          if (rgt[i]) e += (64 >> i);
        end
      end else begin
        e = int'(err_q) * 2;
        if (e > ERR_LIMIT) e = ERR_LIMIT;
        else if (e < -ERR_LIMIT) e = -ERR_LIMIT;
      end
      err_q = e[11:0];
      p = longint'(gain_p) * longint'(e);
      d = longint'(gain_d) * (p - longint'(prev_p));
      prev_p = p[19:0];
      o = p + d;
      ls = SPEED_MAX + o;
      rs = SPEED_MAX - o;
      if (ls > SPEED_MAX) begin
        rs -= ls - SPEED_MAX;
        ls = SPEED_MAX;
        if (rs < -SPEED_MAX) rs = -SPEED_MAX;
      end else if (rs > SPEED_MAX) begin
        ls -= rs - SPEED_MAX;
        rs = SPEED_MAX;
        if (ls < -SPEED_MAX) ls = -SPEED_MAX;
      end
      nl = ls < 0;
      nr = rs < 0;
      if (nl) ls = -ls;
      if (nr) rs = -rs;
      want.ltog = nl != ldir;
      want.rtog = nr != rdir;
      ldir = nl;
      rdir = nr;
      want.lpwm = 10'(scale_pwm(ls));
      want.rpwm = 10'(scale_pwm(rs));
      want.lrev = nl;
      want.rrev = nr;
      want.err = err_q;
      pending_drives.push_back(want);
    endfunction

    function void cmp(string name, longint want_v, longint got_v);
      if (want_v != got_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %0d, got %0d", name, want_v, got_v);
      end
    endfunction

    function void check_drive(drive_result_t got);
      drive_result_t want;
      if (pending_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: pwm %0d/%0d err %0d", got.lpwm, got.rpwm, got.err);
        return;
      end
      want = pending_drives.pop_front();
      cmp("left_pwm", want.lpwm, got.lpwm);
      cmp("right_pwm", want.rpwm, got.rpwm);
      cmp("left_reverse", want.lrev, got.lrev);
      cmp("right_reverse", want.rrev, got.rrev);
      cmp("left_dir_toggle", want.ltog, got.ltog);
      cmp("right_dir_toggle", want.rtog, got.rtog);
      cmp("line_seen", want.seen, got.seen);
      cmp("position_error", want.err, got.err);
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         left_sensors = '0;
  logic [7:0]         right_sensors = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [9:0]         left_pwm;
  logic [9:0]         right_pwm;
  logic               left_reverse;
  logic               right_reverse;
  logic               left_dir_toggle;
  logic               right_dir_toggle;
  logic               line_seen;
  logic signed [11:0] position_error;

  motor_drive_tracker tracker = new();
  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;

  line_follow_pd_motor_drive_top dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .left_sensors     (left_sensors),
    .right_sensors    (right_sensors),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .left_pwm         (left_pwm),
    .right_pwm        (right_pwm),
    .left_reverse     (left_reverse),
    .right_reverse    (right_reverse),
    .left_dir_toggle  (left_dir_toggle),
    .right_dir_toggle (right_dir_toggle),
    .line_seen        (line_seen),
    .position_error   (position_error)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    drive_result_t got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.lpwm = left_pwm;
        got.rpwm = right_pwm;
        got.lrev = left_reverse;
        got.rrev = right_reverse;
        got.ltog = left_dir_toggle;
        got.rtog = right_dir_toggle;
        got.seen = line_seen;
        got.err = position_error;
        tracker.check_drive(got);
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_scan(input logic [7:0] lft, input logic [7:0] rgt);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    left_sensors <= lft;
    right_sensors <= rgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_scan(lft, rgt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_one(input logic [1:0] idx, input logic [7:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic [7:0] gp, input logic [7:0] gd,
                              input logic [7:0] pw);
    drain();
    write_one(CFG_GAIN_P, gp);
    write_one(CFG_GAIN_D, gd);
    write_one(CFG_POWER, pw);
    write_one(CFG_UNUSED, 8'($urandom_range(255)));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_scan();
    int kind;
    logic [2:0] pos;
    logic [7:0] lft, rgt;
    kind = $urandom_range(99);
    pos = 3'($urandom_range(7));
    lft = '0;
    rgt = '0;
    if (kind < 20) begin
      // no line, error keeps doubling
    end else if (kind < 45) begin
      if ($urandom_range(1)) lft[pos] = 1'b1;
      else rgt[pos] = 1'b1;
    end else if (kind < 65) begin
      if ($urandom_range(1)) lft = 8'd3 << $urandom_range(6);
      else rgt = 8'd3 << $urandom_range(6);
    end else if (kind < 80) begin
      lft = 8'd1 << pos;
      rgt = 8'd1 << $urandom_range(7);
    end else begin
      lft = 8'($urandom_range(255));
      rgt = 8'($urandom_range(255));
    end
    send_scan(lft, rgt);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset gains, single weights, bit 7, full ports, doubling to both clamps
    send_scan(8'h00, 8'h00);
    send_scan(8'h01, 8'h00);
    send_scan(8'h00, 8'h01);
    send_scan(8'h40, 8'h00);
    send_scan(8'h00, 8'h40);
    send_scan(8'h80, 8'h00);
    send_scan(8'h00, 8'h80);
    send_scan(8'hFF, 8'hFF);
    send_scan(8'h00, 8'h7F);
    repeat (6) send_scan(8'h00, 8'h00);
    send_scan(8'h7F, 8'h00);
    repeat (6) send_scan(8'h00, 8'h00);

    // maximum gains, power above 100 with the unused data bit set
    program_regs(8'hFF, 8'hFF, 8'hFF);
    send_scan(8'h00, 8'h40);
    send_scan(8'h40, 8'h00);
    send_scan(8'h00, 8'h00);
    send_scan(8'h00, 8'h02);
    send_scan(8'h80, 8'h80);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: program_regs(8'd0, 8'd0, 8'd0);
        1: program_regs(8'd255, 8'd255, 8'd100);
        2: program_regs(8'd1, 8'd0, 8'd100);
        3: program_regs(8'($urandom_range(4)), 8'($urandom_range(3)),
                        8'($urandom_range(255)));
        4: program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
        default: program_regs(8'($urandom_range(2)), 8'd0, 8'd100);
      endcase
      if (ph < 2) begin
        send_idle = 36;
        recv_idle = 79;
      end else if (ph < 4) begin
        send_idle = 79;
        recv_idle = 36;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_scan();
      end
    end

    drain();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/lfpd_pkg.sv
design/lfpd_ctrl.sv
design/lfpd_datapath.sv
design/line_follow_pd_motor_drive_top.sv
bench/line_follow_pd_motor_drive_top_tb.sv
